// ===== rtl/dqi_pkg.sv =====
// ----------------------------------------------------------------------------
// Deque package
// Shared sizes, command and status codes, cell controls and word conversions.
// ----------------------------------------------------------------------------
package dqi_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;

    // Occupancy has to hold DEPTH itself.
    localparam int OCC_W = $clog2(DEPTH + 1);

    // Fixed field widths of the command and result transactions.
    localparam int CMD_W   = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;

    // Positions are compared with the occupancy at the wider of both widths.
    localparam int CMP_W = (OCC_W > POS_W) ? OCC_W : POS_W;

    // Input tdata layout.
    localparam int IN_CMD_LSB   = 0;
    localparam int IN_VALUE_LSB = IN_CMD_LSB + CMD_W;
    localparam int IN_POS_LSB   = IN_VALUE_LSB + VALUE_W;
    localparam int IN_BITS      = IN_POS_LSB + POS_W;
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

    // Output tdata layout.
    localparam int OUT_FRONT_LSB = 0;
    localparam int OUT_BACK_LSB  = OUT_FRONT_LSB + VALUE_W;
    localparam int OUT_COUNT_LSB = OUT_BACK_LSB + VALUE_W;
    localparam int OUT_EMPTY_LSB = OUT_COUNT_LSB + COUNT_W;
    localparam int OUT_STAT_LSB  = OUT_EMPTY_LSB + 1;
    localparam int OUT_BITS      = OUT_STAT_LSB + STAT_W;
    localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_REMOVE_AT  = 3'd4,
        CMD_CLEAR      = 3'd5,
        CMD_QUERY      = 3'd6
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // What a cell loads on the next edge.
    typedef enum logic [1:0] {
        SEL_HOLD = 2'd0,
        SEL_LOAD = 2'd1,
        SEL_PREV = 2'd2,
        SEL_NEXT = 2'd3
    } t_cell_sel;

    function automatic t_word to_word(input logic [VALUE_W-1:0] v);
        logic [63:0] tmp;
        tmp = 64'(v);
        return tmp[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] to_value(input t_word w);
        logic [63:0] tmp;
        tmp = 64'(w);
        return tmp[VALUE_W-1:0];
    endfunction

endpackage

// ===== rtl/dqi_cell.sv =====
// ----------------------------------------------------------------------------
// Deque storage cell
// Holds one entry; loads a pushed word or takes its neighbor's entry.
// ----------------------------------------------------------------------------
module dqi_cell import dqi_pkg::*; (
    input  logic      i_clk,
    input  t_cell_sel i_sel,
    input  t_word     i_word,
    input  t_word     i_prev,
    input  t_word     i_next,
    output t_word     o_data
);

    t_word r_data;
    t_word n_data;

    always_comb begin
        case (i_sel)
            SEL_LOAD: n_data = i_word;
            SEL_PREV: n_data = i_prev;
            SEL_NEXT: n_data = i_next;
            default:  n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== rtl/deque_with_indexed_removal.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue with removal at a position
// A row of storage cells that shift toward the back as a whole, or toward the front from a removed place onward.
// ----------------------------------------------------------------------------
// An accepted command updates the cells, occupancy and status; front and back
// are then read from the updated row into the output register. No new command
// is taken while a result is pending or the output holds one not yet taken.
// Reset empties the deque and drops any pending result; the cell contents are
// not cleared, since entries beyond the occupancy are never read.
module deque_with_indexed_removal import dqi_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // command, entry_value, position
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // front_value, back_value, entry_count, is_empty, status
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    t_cmd              in_cmd;
    t_word             in_word;
    logic [POS_W-1:0]  in_pos;
    logic              in_accept;

    logic [OCC_W-1:0]  r_occ;
    logic [OCC_W-1:0]  n_occ;
    t_status           r_status;
    t_status           n_status;
    logic              r_pend;
    logic              r_out_valid;
    logic [VALUE_W-1:0] r_front;
    logic [VALUE_W-1:0] r_back;
    logic [COUNT_W-1:0] r_count;
    logic              r_empty;

    logic              do_push_front;
    logic              do_push_back;
    logic              do_shift;
    logic [CMP_W-1:0]  shift_from;
    logic              full;
    logic              empty;

    t_word             cell_data [DEPTH];
    t_word             back_word;

    assign in_cmd  = t_cmd'(i_s_axis_tdata[IN_CMD_LSB +: CMD_W]);
    assign in_word = to_word(i_s_axis_tdata[IN_VALUE_LSB +: VALUE_W]);
    assign in_pos  = i_s_axis_tdata[IN_POS_LSB +: POS_W];

    // The result stage must be free by the time the pending result lands.
    assign o_s_axis_tready = !r_pend && (!r_out_valid || i_m_axis_tready);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    assign full  = (r_occ == OCC_W'(DEPTH));
    assign empty = (r_occ == '0);

    always_comb begin
        n_occ         = r_occ;
        n_status      = ST_DONE;
        do_push_front = 1'b0;
        do_push_back  = 1'b0;
        do_shift      = 1'b0;
        shift_from    = '0;
        case (in_cmd)
            CMD_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    do_push_front = 1'b1;
                    n_occ         = r_occ + 1'b1;
                end
            end
            CMD_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    do_push_back = 1'b1;
                    n_occ        = r_occ + 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    do_shift = 1'b1;
                    n_occ    = r_occ - 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_occ = r_occ - 1'b1;
                end
            end
            CMD_REMOVE_AT: begin
                if (CMP_W'(in_pos) >= CMP_W'(r_occ)) begin
                    n_status = ST_EMPTY;
                end else begin
                    do_shift   = 1'b1;
                    shift_from = CMP_W'(in_pos);
                    n_occ      = r_occ - 1'b1;
                end
            end
            CMD_CLEAR: begin
                n_occ = '0;
            end
            default: begin
                n_occ = r_occ;
            end
        endcase
    end

    // A push at the front moves every cell one place back, with the new word
    // entering cell 0; removal closes the gap from the removed place onward.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_word     prev_data;
        t_word     next_data;
        t_cell_sel cell_sel;

        if (i == 0) begin : g_first
            assign prev_data = in_word;
        end else begin : g_mid_prev
            assign prev_data = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign next_data = '0;
        end else begin : g_mid_next
            assign next_data = cell_data[i+1];
        end

        always_comb begin
            cell_sel = SEL_HOLD;
            if (in_accept) begin
                if (do_push_front) begin
                    cell_sel = SEL_PREV;
                end else if (do_push_back && (r_occ == OCC_W'(i))) begin
                    cell_sel = SEL_LOAD;
                end else if (do_shift && (CMP_W'(i) >= shift_from)) begin
                    cell_sel = SEL_NEXT;
                end
            end
        end

        dqi_cell u_cell (
            .i_clk  (i_clk),
            .i_sel  (cell_sel),
            .i_word (in_word),
            .i_prev (prev_data),
            .i_next (next_data),
            .o_data (cell_data[i])
        );
    end

    // Only the last occupied cell contributes to the back word.
    always_comb begin
        back_word = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (r_occ == OCC_W'(k + 1)) begin
                back_word = back_word | cell_data[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_status    <= ST_DONE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_occ    <= n_occ;
                r_status <= n_status;
                r_pend   <= 1'b1;
            end else if (r_pend) begin
                r_pend <= 1'b0;
            end

            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_front <= empty ? '0 : to_value(cell_data[0]);
            r_back  <= empty ? '0 : to_value(back_word);
            r_count <= COUNT_W'(r_occ);
            r_empty <= empty;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;

    always_comb begin
        o_m_axis_tdata = '0;
        o_m_axis_tdata[OUT_FRONT_LSB +: VALUE_W] = r_front;
        o_m_axis_tdata[OUT_BACK_LSB +: VALUE_W]  = r_back;
        o_m_axis_tdata[OUT_COUNT_LSB +: COUNT_W] = r_count;
        o_m_axis_tdata[OUT_EMPTY_LSB]            = r_empty;
        o_m_axis_tdata[OUT_STAT_LSB +: STAT_W]   = r_status;
    end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Deque with removal at a position: self-checking testbench
// Drives command transactions into the deque, tracks the expected contents in
// a queue of words and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module testbench import dqi_pkg::*; ();

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_SHOWN   = 10;
    localparam int TAIL_CYCLES = 8;

    // Code 7 has no enum member; the deque treats it as a query.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    typedef struct packed {
        logic [VALUE_W-1:0] front;
        logic [VALUE_W-1:0] back;
        logic [COUNT_W-1:0] count;
        logic               empty;
        logic [STAT_W-1:0]  status;
    } t_deque_result;

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Expected contents of the deque, front first.
    t_word         stored_words[$];
    t_deque_result predicted_results[$];

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    deque_with_indexed_removal uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, predicted_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Applies one command to the expected contents and returns its result.
    function automatic t_deque_result apply_command(input logic [CMD_W-1:0] cmd,
                                                    input logic [VALUE_W-1:0] value,
                                                    input logic [POS_W-1:0] pos);
        t_deque_result res;
        res.status = ST_DONE;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (stored_words.size() >= DEPTH)
                    res.status = ST_FULL;
                else if (cmd == CMD_PUSH_FRONT)
                    stored_words.insert(0, t_word'(value));
                else
                    stored_words.insert(stored_words.size(), t_word'(value));
            end
            CMD_POP_FRONT: begin
                if (stored_words.size() == 0)
                    res.status = ST_EMPTY;
                else
                    stored_words.delete(0);
            end
            CMD_POP_BACK: begin
                if (stored_words.size() == 0)
                    res.status = ST_EMPTY;
                else
                    stored_words.delete(stored_words.size() - 1);
            end
            CMD_REMOVE_AT: begin
                if (int'(pos) >= stored_words.size())
                    res.status = ST_EMPTY;
                else
                    stored_words.delete(int'(pos));
            end
            CMD_CLEAR: begin
                stored_words.delete();
            end
            default: begin
            end
        endcase
        if (stored_words.size() == 0) begin
            res.front = '0;
            res.back  = '0;
        end else begin
            res.front = VALUE_W'(stored_words[0]);
            res.back  = VALUE_W'(stored_words[stored_words.size() - 1]);
        end
        res.count = COUNT_W'(stored_words.size());
        res.empty = (stored_words.size() == 0);
        return res;
    endfunction

    // Result checker: every result transaction meets the oldest expectation.
    always @(posedge i_clk) begin
        t_deque_result got;
        t_deque_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.front  = m_tdata[OUT_FRONT_LSB +: VALUE_W];
            got.back   = m_tdata[OUT_BACK_LSB +: VALUE_W];
            got.count  = m_tdata[OUT_COUNT_LSB +: COUNT_W];
            got.empty  = m_tdata[OUT_EMPTY_LSB];
            got.status = m_tdata[OUT_STAT_LSB +: STAT_W];
            if (predicted_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("unexpected result: front %h back %h count %0d empty %0d status %0d",
                             got.front, got.back, got.count, got.empty, got.status);
            end else begin
                want = predicted_results[0];
                predicted_results.delete(0);
                if (got.front !== want.front || got.back !== want.back ||
                    got.count !== want.count || got.empty !== want.empty ||
                    got.status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN) begin
                        $display("mismatch at cycle %0d", cycle_count);
                        $display("  expected: front %h back %h count %0d empty %0d status %0d",
                                 want.front, want.back, want.count, want.empty, want.status);
                        $display("  actual:   front %h back %h count %0d empty %0d status %0d",
                                 got.front, got.back, got.count, got.empty, got.status);
                    end
                end
            end
        end
    end

    // Sends one command transaction; returns just after the accepting edge.
    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic [VALUE_W-1:0] value,
                                input logic [POS_W-1:0] pos);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[IN_CMD_LSB +: CMD_W]     = cmd;
        word[IN_VALUE_LSB +: VALUE_W] = value;
        word[IN_POS_LSB +: POS_W]     = pos;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
            @(posedge i_clk);
        while (!s_tready);
        predicted_results.insert(predicted_results.size(), apply_command(cmd, value, pos));
    endtask

    // Holds the sender off until every expected result has come back.
    task automatic wait_for_results();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        return $urandom();
    endfunction

    // Mostly positions that exist, the rest anywhere in the field.
    function automatic logic [POS_W-1:0] random_position();
        if (stored_words.size() > 0 && $urandom_range(99) < 80)
            return POS_W'($urandom_range(stored_words.size() - 1));
        return POS_W'($urandom_range(63));
    endfunction

    task automatic random_push();
        if ($urandom_range(1))
            send_command(CMD_PUSH_FRONT, random_value(), POS_W'($urandom_range(63)));
        else
            send_command(CMD_PUSH_BACK, random_value(), POS_W'($urandom_range(63)));
    endtask

    task automatic test_directed_cases();
        send_command(CMD_QUERY, 32'h0, 6'd0);
        send_command(CMD_POP_FRONT, 32'h0, 6'd0);
        send_command(CMD_POP_BACK, 32'h0, 6'd0);
        send_command(CMD_REMOVE_AT, 32'h0, 6'd0);
        send_command(CMD_PUSH_BACK, 32'h0000_0000, 6'd63);
        send_command(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 6'd0);
        send_command(CMD_PUSH_BACK, 32'h1234_5678, 6'd0);
        send_command(CMD_PUSH_FRONT, 32'hA5A5_A5A5, 6'd0);
        send_command(CMD_QUERY, 32'hFFFF_FFFF, 6'd63);
        send_command(CMD_REMOVE_AT, 32'h0, 6'd4);
        send_command(CMD_REMOVE_AT, 32'h0, 6'd63);
        send_command(CMD_REMOVE_AT, 32'h0, 6'd1);
        send_command(CMD_UNUSED, 32'hDEAD_BEEF, 6'd63);
        send_command(CMD_POP_FRONT, 32'h0, 6'd0);
        send_command(CMD_POP_BACK, 32'h0, 6'd0);
        send_command(CMD_REMOVE_AT, 32'h0, 6'd0);
        send_command(CMD_POP_FRONT, 32'h0, 6'd0);
        send_command(CMD_PUSH_BACK, 32'h0000_0001, 6'd0);
        send_command(CMD_PUSH_FRONT, 32'h8000_0000, 6'd0);
        send_command(CMD_CLEAR, 32'h0, 6'd0);
        send_command(CMD_CLEAR, 32'h0, 6'd0);
        send_command(CMD_QUERY, 32'h0, 6'd0);
    endtask

    // Fills the store to the top, hits the full bound, then empties it again.
    task automatic test_fill_and_drain();
        send_command(CMD_CLEAR, random_value(), POS_W'($urandom_range(63)));
        while (stored_words.size() < DEPTH)
            random_push();
        repeat (3) random_push();
        send_command(CMD_REMOVE_AT, random_value(), 6'd63);
        send_command(CMD_PUSH_BACK, random_value(), 6'd0);
        send_command(CMD_REMOVE_AT, random_value(), 6'd0);
        send_command(CMD_QUERY, random_value(), POS_W'($urandom_range(63)));
        while (stored_words.size() > DEPTH / 2)
            send_command(CMD_REMOVE_AT, random_value(), random_position());
        while (stored_words.size() > 0) begin
            if ($urandom_range(1))
                send_command(CMD_POP_FRONT, random_value(), POS_W'($urandom_range(63)));
            else
                send_command(CMD_POP_BACK, random_value(), POS_W'($urandom_range(63)));
        end
        send_command(CMD_POP_FRONT, random_value(), 6'd0);
        send_command(CMD_POP_BACK, random_value(), 6'd0);
        send_command(CMD_REMOVE_AT, random_value(), POS_W'($urandom_range(63)));
    endtask

    // Random traffic that keeps the occupancy wandering over the whole range.
    task automatic test_random_traffic(input int count);
        int push_pct;
        int pick;
        repeat (count) begin
            push_pct = (stored_words.size() < DEPTH / 2) ? 60 : 40;
            pick = $urandom_range(99);
            if (pick < push_pct) begin
                random_push();
            end else begin
                pick = $urandom_range(99);
                if (pick < 25)
                    send_command(CMD_POP_FRONT, random_value(), random_position());
                else if (pick < 50)
                    send_command(CMD_POP_BACK, random_value(), random_position());
                else if (pick < 90)
                    send_command(CMD_REMOVE_AT, random_value(), random_position());
                else if (pick < 92)
                    send_command(CMD_CLEAR, random_value(), random_position());
                else if (pick < 97)
                    send_command(CMD_QUERY, random_value(), random_position());
                else
                    send_command(CMD_UNUSED, random_value(), random_position());
            end
        end
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        test_fill_and_drain();
        wait_for_results();
        test_random_traffic(440);
        wait_for_results();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct   = 35;
        sink_stall_pct = 80;
        test_directed_cases();
        wait_for_results();
        run_phase(35, 80);
        run_phase(80, 35);
        run_phase(0, 0);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && predicted_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dqi_pkg.sv
rtl/dqi_cell.sv
rtl/deque_with_indexed_removal.sv
dv/testbench.sv
